// ===== src/stis_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String table sort package
// Field widths, default sizes, operation codes and sequencer states shared
// by the interfaces and the modules of the string table.
// ----------------------------------------------------------------------------
package stis_pkg;

   localparam int OPERATION_W      = 2;
   localparam int SLOT_W           = 3;
   localparam int POSITION_W       = 5;
   localparam int DATA_W           = 8;

   localparam int NUM_STRINGS_DEF  = 5;
   localparam int STRING_BYTES_DEF = 21;

   typedef enum logic [OPERATION_W-1:0] {
      OP_WRITE = 2'd0,
      OP_SORT  = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_RD_ISSUE,
      S_RD_EMIT,
      S_KEY,
      S_LOAD,
      S_CMP_ISSUE,
      S_CMP_EVAL,
      S_SORT_DONE
   } state_type;

endpackage

// ===== src/stis_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String table channel interfaces
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface stis_req_if;
   logic                             valid;
   logic                             ready;
   logic [stis_pkg::OPERATION_W-1:0] operation;
   logic [stis_pkg::SLOT_W-1:0]      slot;
   logic [stis_pkg::POSITION_W-1:0]  position;
   logic [stis_pkg::DATA_W-1:0]      byte_value;

   modport source (output valid, output operation, output slot, output position,
                   output byte_value, input ready);
   modport sink   (input valid, input operation, input slot, input position,
                   input byte_value, output ready);
endinterface

interface stis_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        status;
   logic [stis_pkg::DATA_W-1:0] data_byte;
   logic                        last;

   modport source (output valid, output status, output data_byte, output last,
                   input ready);
   modport sink   (input valid, input status, input data_byte, input last,
                   output ready);
endinterface

// ===== src/stis_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String store
// Byte memory for all strings with one write port and two registered read
// ports. After reset it sweeps every byte to zero and reports busy.
// ----------------------------------------------------------------------------
module stis_store #(
   parameter int DEPTH  = stis_pkg::NUM_STRINGS_DEF * stis_pkg::STRING_BYTES_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        reset,
   output logic                        busy,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [stis_pkg::DATA_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr_a,
   input  logic [ADDR_W-1:0]           rd_addr_b,
   output logic [stis_pkg::DATA_W-1:0] rd_data_a,
   output logic [stis_pkg::DATA_W-1:0] rd_data_b
);
   import stis_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic              clr_ff;
   logic              clr_in;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] clr_addr_in;
   logic [DATA_W-1:0] data_a_ff;
   logic [DATA_W-1:0] data_b_ff;

   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_a_ff <= mem[rd_addr_a];
         data_b_ff <= mem[rd_addr_b];
      end
   end

   assign busy      = clr_ff;
   assign rd_data_a = data_a_ff;
   assign rd_data_b = data_b_ff;

endmodule

// ===== src/stis_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String table sequencer
// Holds the order table and steps writes, reads and the insertion sort
// through one shared byte comparator and the store's read ports.
// ----------------------------------------------------------------------------
module stis_seq #(
   parameter int NUM_STRINGS  = stis_pkg::NUM_STRINGS_DEF,
   parameter int STRING_BYTES = stis_pkg::STRING_BYTES_DEF,
   parameter int ADDR_W       = $clog2(NUM_STRINGS * STRING_BYTES)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [stis_pkg::OPERATION_W-1:0] req_operation,
   input  logic [stis_pkg::SLOT_W-1:0]      req_slot,
   input  logic [stis_pkg::POSITION_W-1:0]  req_position,
   input  logic [stis_pkg::DATA_W-1:0]      req_byte_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_status,
   output logic [stis_pkg::DATA_W-1:0]      rsp_data_byte,
   output logic                            rsp_last,
   input  logic                            store_busy,
   output logic                            store_wr_en,
   output logic [ADDR_W-1:0]               store_wr_addr,
   output logic [stis_pkg::DATA_W-1:0]      store_wr_data,
   output logic                            store_rd_en,
   output logic [ADDR_W-1:0]               store_rd_addr_a,
   output logic [ADDR_W-1:0]               store_rd_addr_b,
   input  logic [stis_pkg::DATA_W-1:0]      store_rd_data_a,
   input  logic [stis_pkg::DATA_W-1:0]      store_rd_data_b
);
   import stis_pkg::*;

   localparam int IDX_W  = $clog2(NUM_STRINGS);
   localparam int BYTE_W = $clog2(STRING_BYTES);

   state_type               state_ff, state_in;
   logic [OPERATION_W-1:0]  op_ff;
   logic [SLOT_W-1:0]       slot_ff;
   logic [POSITION_W-1:0]   pos_ff;
   logic [DATA_W-1:0]       val_ff;
   logic [IDX_W-1:0]        phys_ff, phys_in;
   logic [BYTE_W-1:0]       k_ff, k_in;
   logic [IDX_W-1:0]        i_ff, i_in;
   logic [IDX_W-1:0]        j_ff, j_in;
   logic [IDX_W-1:0]        key_ff, key_in;
   logic [IDX_W-1:0]        cand_ff, cand_in;
   logic [IDX_W-1:0]        ord_ff [NUM_STRINGS];
   logic [IDX_W-1:0]        ord_in [NUM_STRINGS];
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    accept;
   logic                    rsp_free;
   logic                    slot_ok;
   logic                    pos_ok;
   logic                    last_byte;
   logic [IDX_W-1:0]        ord_idx;
   logic [IDX_W-1:0]        ord_rd;
   logic [IDX_W-1:0]        phys_sel;

   function automatic logic [ADDR_W-1:0] byte_addr(input logic [IDX_W-1:0] row,
                                                   input logic [BYTE_W-1:0] col);
      byte_addr = ADDR_W'(32'(row) * STRING_BYTES + 32'(col));
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE) && !store_busy;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign slot_ok   = 32'(slot_ff) < NUM_STRINGS;
   assign pos_ok    = 32'(pos_ff) < STRING_BYTES;
   assign last_byte = k_ff == BYTE_W'(STRING_BYTES - 1);
   assign ord_rd    = ord_ff[ord_idx];
   assign phys_sel  = (32'(ord_rd) < NUM_STRINGS) ? ord_rd : '0;

   always_comb begin
      case (state_ff)
         S_KEY:   ord_idx = i_ff;
         S_LOAD:  ord_idx = j_ff;
         default: ord_idx = IDX_W'(slot_ff);
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      phys_in       = phys_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      key_in        = key_ff;
      cand_in       = cand_ff;
      ord_in        = ord_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      store_wr_en   = 1'b0;
      store_wr_addr = byte_addr(phys_sel, BYTE_W'(pos_ff));
      store_wr_data = val_ff;
      store_rd_en   = 1'b0;
      store_rd_addr_a = byte_addr(phys_ff, k_ff);
      store_rd_addr_b = byte_addr(key_ff, k_ff);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (op_ff)
               OP_SORT: begin
                  i_in     = IDX_W'(1);
                  state_in = S_KEY;
               end
               OP_WRITE, OP_READ: begin
                  if (!slot_ok || op_ff == OP_WRITE) begin
                     if (rsp_free) begin
                        store_wr_en   = slot_ok && pos_ok;
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = !slot_ok;
                        rsp_data_in   = '0;
                        rsp_last_in   = 1'b1;
                        state_in      = S_IDLE;
                     end
                  end else begin
                     phys_in  = phys_sel;
                     k_in     = '0;
                     state_in = S_RD_ISSUE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_RD_ISSUE: begin
            store_rd_en = 1'b1;
            state_in    = S_RD_EMIT;
         end
         S_RD_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = 1'b0;
               rsp_data_in   = store_rd_data_a;
               rsp_last_in   = last_byte;
               if (last_byte) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_RD_ISSUE;
               end
            end
         end
         S_KEY: begin
            key_in   = ord_rd;
            j_in     = i_ff - 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            cand_in  = ord_rd;
            k_in     = '0;
            state_in = S_CMP_ISSUE;
         end
         S_CMP_ISSUE: begin
            store_rd_en     = 1'b1;
            store_rd_addr_a = byte_addr(cand_ff, k_ff);
            state_in        = S_CMP_EVAL;
         end
         S_CMP_EVAL: begin
            if (store_rd_data_a == store_rd_data_b && store_rd_data_a != '0 && !last_byte) begin
               k_in     = k_ff + 1'b1;
               state_in = S_CMP_ISSUE;
            end else if (store_rd_data_a > store_rd_data_b) begin
               ord_in[IDX_W'(32'(j_ff) + 1)] = cand_ff;
               if (j_ff == '0) begin
                  ord_in[0] = key_ff;
                  if (i_ff == IDX_W'(NUM_STRINGS - 1)) begin
                     state_in = S_SORT_DONE;
                  end else begin
                     i_in     = i_ff + 1'b1;
                     state_in = S_KEY;
                  end
               end else begin
                  j_in     = j_ff - 1'b1;
                  state_in = S_LOAD;
               end
            end else begin
               ord_in[IDX_W'(32'(j_ff) + 1)] = key_ff;
               if (i_ff == IDX_W'(NUM_STRINGS - 1)) begin
                  state_in = S_SORT_DONE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_KEY;
               end
            end
         end
         S_SORT_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = 1'b0;
               rsp_data_in   = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int e = 0; e < NUM_STRINGS; e++) begin
            ord_ff[e] <= IDX_W'(e);
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ord_ff       <= ord_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_operation;
         slot_ff <= req_slot;
         pos_ff  <= req_position;
         val_ff  <= req_byte_value;
      end
      phys_ff       <= phys_in;
      k_ff          <= k_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      key_ff        <= key_in;
      cand_ff       <= cand_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_data_byte = rsp_data_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ===== src/string_table_insertion_sort.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String table with insertion sort
// Stores NUM_STRINGS strings of STRING_BYTES bytes, writes single bytes,
// sorts the slot order by bytewise string compare and reads out a slot.
//
//   Channel   Direction  Transaction
//   req_bus   in         operation, slot, position, byte_value
//   rsp_bus   out        status, data_byte, last
//
// A read makes one store read per byte of the slot's string.
// A sort fetches each key and each candidate and compares them byte by byte in
// the shared comparator, over at most NUM_STRINGS * (NUM_STRINGS - 1) / 2
// comparisons.
// After reset the store is cleared with req_bus.ready low; a full response
// register stalls the sequencer.
// ----------------------------------------------------------------------------
module string_table_insertion_sort #(
   parameter int NUM_STRINGS  = stis_pkg::NUM_STRINGS_DEF,
   parameter int STRING_BYTES = stis_pkg::STRING_BYTES_DEF
) (
   input  logic     clock,
   input  logic     reset,
   stis_req_if.sink   req_bus,
   stis_rsp_if.source rsp_bus
);
   import stis_pkg::*;

   localparam int DEPTH  = NUM_STRINGS * STRING_BYTES;
   localparam int ADDR_W = $clog2(DEPTH);

   logic              store_busy;
   logic              store_wr_en;
   logic [ADDR_W-1:0] store_wr_addr;
   logic [DATA_W-1:0] store_wr_data;
   logic              store_rd_en;
   logic [ADDR_W-1:0] store_rd_addr_a;
   logic [ADDR_W-1:0] store_rd_addr_b;
   logic [DATA_W-1:0] store_rd_data_a;
   logic [DATA_W-1:0] store_rd_data_b;

   stis_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .busy      (store_busy),
      .wr_en     (store_wr_en),
      .wr_addr   (store_wr_addr),
      .wr_data   (store_wr_data),
      .rd_en     (store_rd_en),
      .rd_addr_a (store_rd_addr_a),
      .rd_addr_b (store_rd_addr_b),
      .rd_data_a (store_rd_data_a),
      .rd_data_b (store_rd_data_b)
   );

   stis_seq #(
      .NUM_STRINGS  (NUM_STRINGS),
      .STRING_BYTES (STRING_BYTES),
      .ADDR_W       (ADDR_W)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_bus.valid),
      .req_ready       (req_bus.ready),
      .req_operation   (req_bus.operation),
      .req_slot        (req_bus.slot),
      .req_position    (req_bus.position),
      .req_byte_value  (req_bus.byte_value),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_status      (rsp_bus.status),
      .rsp_data_byte   (rsp_bus.data_byte),
      .rsp_last        (rsp_bus.last),
      .store_busy      (store_busy),
      .store_wr_en     (store_wr_en),
      .store_wr_addr   (store_wr_addr),
      .store_wr_data   (store_wr_data),
      .store_rd_en     (store_rd_en),
      .store_rd_addr_a (store_rd_addr_a),
      .store_rd_addr_b (store_rd_addr_b),
      .store_rd_data_a (store_rd_data_a),
      .store_rd_data_b (store_rd_data_b)
   );

endmodule

// ===== tb/string_table_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String table response checker
// Watches both channels of the string table. Every accepted request updates
// a private copy of the string store and the slot order, and queues the
// response transactions that the request should produce. Every accepted
// response is compared with the oldest queued one.
// ----------------------------------------------------------------------------
module string_table_check #(
   parameter int NUM_STRINGS  = stis_pkg::NUM_STRINGS_DEF,
   parameter int STRING_BYTES = stis_pkg::STRING_BYTES_DEF
) (
   input  logic clock,
   input  logic reset,
   stis_req_if  req_mon,
   stis_rsp_if  rsp_mon,
   output int   fail_count,
   output int   outstanding,
   output int   checked
);
   import stis_pkg::*;

   typedef struct packed {
      logic              status;
      logic [DATA_W-1:0] data_byte;
      logic              last;
   } rsp_beat_type;

   logic [DATA_W-1:0] text_store [NUM_STRINGS][STRING_BYTES];
   logic [SLOT_W-1:0] slot_map [NUM_STRINGS];
   rsp_beat_type      expected_beats [$];

   function automatic int text_order(input logic [SLOT_W-1:0] a, input logic [SLOT_W-1:0] b);
      int k;
      for (k = 0; k < STRING_BYTES; k++) begin
         if (text_store[a][k] != text_store[b][k])
            return (text_store[a][k] < text_store[b][k]) ? -1 : 1;
         if (text_store[a][k] == '0)
            return 0;
      end
      return 0;
   endfunction

   task automatic sort_slots();
      int                i;
      int                j;
      logic [SLOT_W-1:0] key;
      for (i = 1; i < NUM_STRINGS; i++) begin
         key = slot_map[i];
         j   = i - 1;
         while (j >= 0 && text_order(slot_map[j], key) > 0) begin
            slot_map[j+1] = slot_map[j];
            j--;
         end
         slot_map[j+1] = key;
      end
   endtask

   task automatic predict_request();
      logic [SLOT_W-1:0] phys;
      int                k;
      case (req_mon.operation)
         OP_SORT: begin
            sort_slots();
            expected_beats.push_back('{1'b0, 8'h00, 1'b1});
         end
         OP_WRITE, OP_READ: begin
            if (req_mon.slot >= NUM_STRINGS) begin
               expected_beats.push_back('{1'b1, 8'h00, 1'b1});
            end else begin
               phys = slot_map[req_mon.slot];
               if (phys >= NUM_STRINGS)
                  phys = '0;
               if (req_mon.operation == OP_WRITE) begin
                  if (req_mon.position < STRING_BYTES)
                     text_store[phys][req_mon.position] = req_mon.byte_value;
                  expected_beats.push_back('{1'b0, 8'h00, 1'b1});
               end else begin
                  for (k = 0; k < STRING_BYTES; k++)
                     expected_beats.push_back('{1'b0, text_store[phys][k],
                                               k == STRING_BYTES - 1});
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : watch
      rsp_beat_type got;
      rsp_beat_type want;
      int           i;
      int           k;
      if (reset) begin
         for (i = 0; i < NUM_STRINGS; i++) begin
            slot_map[i] = i[SLOT_W-1:0];
            for (k = 0; k < STRING_BYTES; k++)
               text_store[i][k] = '0;
         end
         expected_beats.delete();
         fail_count = 0;
         checked    = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            predict_request();
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.status, rsp_mon.data_byte, rsp_mon.last};
            checked++;
            if (expected_beats.size() == 0) begin
               $display("%0t: unexpected response, got status %0d data %02h last %0d",
                        $time, got.status, got.data_byte, got.last);
               fail_count++;
            end else begin
               want = expected_beats.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch, expected status %0d data %02h last %0d, %s",
                           $time, want.status, want.data_byte, want.last,
                           $sformatf("got status %0d data %02h last %0d",
                                     got.status, got.data_byte, got.last));
                  fail_count++;
               end
            end
         end
      end
      outstanding = expected_beats.size();
   end

endmodule

// ===== tb/tb_string_table_insertion_sort.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String table insertion sort testbench
// Drives byte writes, sorts and slot reads into the string table, first a
// directed set of edge cases and then random strings with shared prefixes,
// unterminated strings and noise. The sender works in bursts and the
// receiver stalls on its own pattern; the checker predicts every response.
// ----------------------------------------------------------------------------
module tb_string_table_insertion_sort;
   import stis_pkg::*;

   localparam int              N_STR        = NUM_STRINGS_DEF;
   localparam int              S_BYTES      = STRING_BYTES_DEF;
   localparam int              RANDOM_ITEMS = 160;
   localparam int              IDLE_LIMIT   = 4000;
   localparam int              LONG_HOLD    = 400;
   localparam logic [OPERATION_W-1:0] OP_UNUSED = 2'd3;

   logic clock;
   logic reset;
   logic hold_req;
   logic hold_active;
   int   fail_count;
   int   outstanding;
   int   checked;
   int   sent        = 0;
   int   reads_sent  = 0;
   int   sorts_sent  = 0;
   int   burst_left  = 0;
   int   idle_cycles = 0;
   bit   gaps_on     = 1'b0;

   stis_req_if req_bus ();
   stis_rsp_if rsp_bus ();

   string_table_insertion_sort #(
      .NUM_STRINGS  (N_STR),
      .STRING_BYTES (S_BYTES)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   string_table_check #(
      .NUM_STRINGS  (N_STR),
      .STRING_BYTES (S_BYTES)
   ) table_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .checked     (checked)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   task automatic send_item(input int op, input int slot, input int pos, input int val);
      int gap;
      if (gaps_on && burst_left == 0) begin
         gap        = $urandom_range(0, 12);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0)
         burst_left--;
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= op[OPERATION_W-1:0];
      req_bus.slot       <= slot[SLOT_W-1:0];
      req_bus.position   <= pos[POSITION_W-1:0];
      req_bus.byte_value <= val[DATA_W-1:0];
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sent++;
      if (op == OP_READ)
         reads_sent++;
      if (op == OP_SORT)
         sorts_sent++;
   endtask

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: watchdog expired after %0d cycles without a transaction",
                  $time, idle_cycles);
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : rsp_pacer
      int mode;
      int seg_len;
      bit held;
      held = 1'b0;
      rsp_bus.ready <= 1'b0;
      hold_active   <= 1'b0;
      forever begin
         if (hold_req === 1'b1 && !held) begin
            held = 1'b1;
            rsp_bus.ready <= 1'b0;
            hold_active   <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_active   <= 1'b0;
         end else begin
            mode    = $urandom_range(0, 2);
            seg_len = $urandom_range(10, 60);
            repeat (seg_len) begin
               case (mode)
                  0:       rsp_bus.ready <= 1'b1;
                  1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
                  default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      int         base;
      int         pick;
      int         s;
      int         len;
      int         p;
      logic [7:0] ch;
      bit         hold_done;
      bit         pause_done;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      reset              <= 1'b1;
      hold_req           <= 1'b0;
      req_bus.valid      <= 1'b0;
      req_bus.operation  <= OP_WRITE;
      req_bus.slot       <= '0;
      req_bus.position   <= '0;
      req_bus.byte_value <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_item(OP_READ, 0, 0, 0);
      send_item(OP_WRITE, 0, 0, 8'hFF);
      send_item(OP_WRITE, 0, S_BYTES - 1, 8'h01);
      send_item(OP_WRITE, 0, S_BYTES, 8'h55);
      send_item(OP_WRITE, 0, 31, 8'hAA);
      send_item(OP_WRITE, 7, 31, 8'hFF);
      send_item(OP_READ, N_STR, 0, 0);
      send_item(OP_READ, 7, 0, 0);
      send_item(OP_UNUSED, 7, 31, 8'hFF);
      send_item(OP_WRITE, 1, 0, 8'h00);
      send_item(OP_WRITE, 2, 0, 8'h62);
      send_item(OP_WRITE, 3, 0, 8'h61);
      send_item(OP_WRITE, 4, 0, 8'h62);
      send_item(OP_WRITE, 4, 1, 8'h00);
      send_item(OP_READ, 0, 0, 0);
      send_item(OP_SORT, 7, 31, 8'hFF);
      send_item(OP_READ, 0, 0, 0);
      send_item(OP_READ, 4, 0, 0);
      send_item(OP_WRITE, 4, 0, 8'h80);
      send_item(OP_SORT, 0, 0, 0);
      send_item(OP_READ, 3, 0, 0);
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);

      gaps_on = 1'b1;
      base    = sent;
      while (sent - base < RANDOM_ITEMS) begin
         if (!hold_done && sent - base >= 60) begin
            // Stall the response side and keep offering, so that the block fills up.
            req_bus.valid <= 1'b0;
            hold_req      <= 1'b1;
            do @(posedge clock); while (hold_active !== 1'b1);
            gaps_on = 1'b0;
            for (p = 0; p < 16; p++)
               send_item((p % 3 == 0) ? OP_READ : OP_WRITE, $urandom_range(0, N_STR - 1),
                         $urandom_range(0, S_BYTES - 1), $urandom_range(0, 255));
            gaps_on   = 1'b1;
            hold_done = 1'b1;
         end else if (!pause_done && sent - base >= 120) begin
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (outstanding != 0);
            pause_done = 1'b1;
         end else begin
            pick = $urandom_range(0, 19);
            if (pick < 8) begin
               // A string from a small alphabet, so that prefixes and ties are common.
               s   = $urandom_range(0, N_STR - 1);
               len = ($urandom_range(0, 7) == 0) ? S_BYTES : $urandom_range(0, 4);
               for (p = 0; p < len; p++) begin
                  case ($urandom_range(0, 3))
                     0:       ch = 8'h41;
                     1:       ch = 8'h42;
                     2:       ch = 8'($urandom_range(1, 255));
                     default: ch = $urandom_range(0, 1) ? 8'hFF : 8'h01;
                  endcase
                  if (len == S_BYTES && p < S_BYTES - 1)
                     ch = 8'h41;
                  send_item(OP_WRITE, s, p, ch);
               end
               if (len < S_BYTES) begin
                  send_item(OP_WRITE, s, len, 0);
                  if ($urandom_range(0, 5) == 0)
                     for (p = len + 1; p < S_BYTES; p++)
                        send_item(OP_WRITE, s, p, 0);
               end
            end else if (pick < 11) begin
               send_item(OP_SORT, $urandom_range(0, 7), $urandom_range(0, 31),
                         $urandom_range(0, 255));
            end else if (pick < 16) begin
               send_item(OP_READ, $urandom_range(0, N_STR - 1), $urandom_range(0, 31),
                         $urandom_range(0, 255));
            end else begin
               send_item($urandom_range(0, 3), $urandom_range(0, 7), $urandom_range(0, 31),
                         $urandom_range(0, 255));
            end
         end
      end

      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (2 * S_BYTES + 20) @(posedge clock);

      $display("Sent %0d requests (%0d reads, %0d sorts) with invalid slots, stray positions,",
               sent, reads_sent, sorts_sent);
      $display("unused codes and a long response stall; %0d responses were compared.", checked);
      if (fail_count == 0 && outstanding == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
